// ===== rtl/tsg_pkg.sv =====
// Shared types and constants of the touch scaler and gesture detector.
// Used by tsg_ctrl, tsg_datapath and touch_scale_and_gesture; no dependencies.
`default_nettype none

package tsg_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_CROP_X_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_X_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_Y_LOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_Y_HIGH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_RADIUS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SLIDE_DIST   = 3'd7;

  // Register widths fixed by the register map
  localparam int CROP_W  = 12;
  localparam int SIZE_W  = 13;
  localparam int TAP_W   = 8;
  localparam int SLIDE_W = 12;

  // Gesture codes
  localparam int GEST_W = 2;
  localparam logic [GEST_W-1:0] GEST_NONE  = 2'd0;
  localparam logic [GEST_W-1:0] GEST_TAP   = 2'd1;
  localparam logic [GEST_W-1:0] GEST_RIGHT = 2'd2;
  localparam logic [GEST_W-1:0] GEST_LEFT  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;    // latch the input beat
    logic mul;       // form |raw-lo|*size for the selected axis, load divider
    logic div_step;  // one restoring division step
    logic store;     // clamp quotient, store the axis result
    logic finish;    // update report state and load the output register
    logic axis;      // 0 selects x, 1 selects y
  } tsg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic changed;   // incoming poll differs from the last one taken
    logic out_busy;  // output register holds a beat not yet taken
  } tsg_status_t;

endpackage

`default_nettype wire

// ===== rtl/touch_scale_and_gesture.sv =====
// Top level of the touch scaler and gesture detector.
// Depends on tsg_pkg, tsg_ctrl and tsg_datapath.
//
//  Channel  Direction  Handshake          Contents
//  in_      slave      tvalid/tready      one sensor poll per beat
//  out_     master     tvalid/tready      one report per poll
//  cfg_     write      wr_en              register index and data, no read-back
//
// An unchanged poll goes from the accept straight to the finish state, which loads
// the report into the output register once that is free. A changed poll first runs
// multiply, divide and store for x, then for y, on the single restoring divider, one
// quotient bit per cycle, shared by both axes. in_tready is high only while the sequencer
// is idle; a waiting report blocks only the next report load, not the next poll.
// Reset is synchronous and active low and restores the register defaults.
`default_nettype none

module touch_scale_and_gesture
  import tsg_pkg::*;
#(
  parameter int COORD_BITS = 12,
  localparam int IN_W  = ((1 + 2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 + 6 * COORD_BITS + GEST_W + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input beats
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [0] is_touched, raw_x, raw_y, zero fill
  input  wire logic [IN_W-1:0]       in_tdata,
  // report beats
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [0] updated, touched_now, pos_x, pos_y, press_x, press_y, lift_x, lift_y,
  // gesture, zero fill
  output logic [OUT_W-1:0]           out_tdata,
  // configuration writes
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int M        = (COORD_BITS > CROP_W) ? COORD_BITS : CROP_W;
  localparam int NUM_W    = M + SIZE_W;

  tsg_cmd_t    cmd;
  tsg_status_t status;

  logic                  updated, touched_now;
  logic [COORD_BITS-1:0] pos_x, pos_y, press_x, press_y, lift_x, lift_y;
  logic [GEST_W-1:0]     gesture;

  tsg_ctrl #(
    .NUM_W (NUM_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tsg_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .is_touched  (in_tdata[0]),
    .raw_x       (in_tdata[COORD_BITS:1]),
    .raw_y       (in_tdata[2*COORD_BITS:COORD_BITS+1]),
    .cmd         (cmd),
    .status      (status),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .updated     (updated),
    .touched_now (touched_now),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .press_x     (press_x),
    .press_y     (press_y),
    .lift_x      (lift_x),
    .lift_y      (lift_y),
    .gesture     (gesture)
  );

  // Pack the report, first field in the lowest bits
  assign out_tdata = OUT_W'({gesture, lift_y, lift_x, press_y, press_x,
                             pos_y, pos_x, touched_now, updated});

endmodule

`default_nettype wire

// ===== rtl/tsg_ctrl.sv =====
// Sequencer of the touch scaler: accept, per-axis multiply/divide/store for a changed poll, finish.
// Depends on tsg_pkg; drives tsg_datapath through tsg_cmd_t.
`default_nettype none

module tsg_ctrl
  import tsg_pkg::*;
#(
  parameter int NUM_W = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire tsg_status_t status,
  output tsg_cmd_t         cmd
);

  localparam int CNT_W = $clog2(NUM_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             axis_r, axis_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next-state and command decode
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    axis_nxt     = axis_r;
    cmd          = '0;
    cmd.axis     = axis_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          axis_nxt   = 1'b0;
          state_nxt  = status.changed ? S_MUL : S_FIN;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (axis_r) begin
          state_nxt = S_FIN;
        end else begin
          axis_nxt  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_FIN: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

  // The output register is never overwritten while a beat waits in it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !status.out_busy)
    else $error("finish issued while output register busy");

  // A changed poll starts the x-axis multiply in the next cycle.
  a_changed_starts_x: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && status.changed) |=> (state_r == S_MUL && !axis_r))
    else $error("changed poll did not start x-axis scaling");

  // The division step counter stays inside the quotient width.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (32'(cnt_r) < NUM_W))
    else $error("division step counter out of range");

  // The y axis is only divided after the x axis has been stored.
  a_y_after_x: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL && axis_r) |-> $past(state_r == S_STORE))
    else $error("y-axis scaling entered without x-axis store");

endmodule

`default_nettype wire

// ===== rtl/tsg_datapath.sv =====
// Datapath of the touch scaler: config registers, multiplier, serial divider,
// clamp, report state and output register. Depends on tsg_pkg.
`default_nettype none

module tsg_datapath
  import tsg_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input payload
  input  wire logic                  is_touched,
  input  wire logic [COORD_BITS-1:0] raw_x,
  input  wire logic [COORD_BITS-1:0] raw_y,
  // control
  input  wire tsg_cmd_t              cmd,
  output tsg_status_t                status,
  // output channel
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic                       updated,
  output logic                       touched_now,
  output logic [COORD_BITS-1:0]      pos_x,
  output logic [COORD_BITS-1:0]      pos_y,
  output logic [COORD_BITS-1:0]      press_x,
  output logic [COORD_BITS-1:0]      press_y,
  output logic [COORD_BITS-1:0]      lift_x,
  output logic [COORD_BITS-1:0]      lift_y,
  output logic [GEST_W-1:0]          gesture
);

  localparam int CB    = COORD_BITS;
  localparam int M     = (CB > CROP_W) ? CB : CROP_W;   // common operand width
  localparam int NUM_W = M + SIZE_W;                    // |raw-lo|*size
  localparam int TW    = (CB > SIZE_W) ? CB : SIZE_W;   // clamp compare width
  localparam int GW    = M + 2;                         // gesture compare width

  // Configuration registers
  logic [CROP_W-1:0]  crop_x_low_r, crop_x_high_r, crop_y_low_r, crop_y_high_r;
  logic [SIZE_W-1:0]  screen_w_r, screen_h_r;
  logic [TAP_W-1:0]   tap_radius_r;
  logic [SLIDE_W-1:0] slide_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_x_low_r  <= CROP_W'(1);
      crop_x_high_r <= CROP_W'(1);
      crop_y_low_r  <= CROP_W'(1);
      crop_y_high_r <= CROP_W'(1);
      screen_w_r    <= SIZE_W'(1);
      screen_h_r    <= SIZE_W'(1);
      tap_radius_r  <= TAP_W'(10);
      slide_dist_r  <= SLIDE_W'(30);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CROP_X_LOW:  crop_x_low_r  <= cfg_data[CROP_W-1:0];
        REG_CROP_X_HIGH: crop_x_high_r <= cfg_data[CROP_W-1:0];
        REG_CROP_Y_LOW:  crop_y_low_r  <= cfg_data[CROP_W-1:0];
        REG_CROP_Y_HIGH: crop_y_high_r <= cfg_data[CROP_W-1:0];
        REG_SCREEN_W:    screen_w_r    <= cfg_data[SIZE_W-1:0];
        REG_SCREEN_H:    screen_h_r    <= cfg_data[SIZE_W-1:0];
        REG_TAP_RADIUS:  tap_radius_r  <= cfg_data[TAP_W-1:0];
        REG_SLIDE_DIST:  slide_dist_r  <= cfg_data[SLIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Report state
  logic          last_touch_r;
  logic [CB-1:0] last_x_r, last_y_r;
  logic          rep_touched_r;
  logic [CB-1:0] rep_x_r, rep_y_r, rep_press_x_r, rep_press_y_r;
  logic [CB-1:0] rep_lift_x_r, rep_lift_y_r;
  logic [GEST_W-1:0] rep_gesture_r;
  logic          updated_r;
  logic          out_valid_r;

  // Latched poll
  logic          t_r;
  logic [CB-1:0] rx_r, ry_r;
  logic          changed_r;

  assign status.changed  = (is_touched != last_touch_r) || (raw_x != last_x_r) ||
                           (raw_y != last_y_r);
  assign status.out_busy = out_valid_r && !out_tready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r       <= is_touched;
      rx_r      <= raw_x;
      ry_r      <= raw_y;
      changed_r <= status.changed;
    end
  end

  // Axis operand selection and multiply
  logic [CB-1:0]        raw_sel;
  logic [CROP_W-1:0]    lo_sel, hi_sel;
  logic [SIZE_W-1:0]    size_sel;
  logic signed [M:0]    diff;
  logic [M-1:0]         diff_mag;
  logic signed [CROP_W:0] span;
  logic [CROP_W-1:0]    span_mag;
  logic                 force_zero;
  logic [TW-1:0]        size_m1_w, mask_w;
  logic [CB-1:0]        top;

  always_comb begin
    raw_sel  = cmd.axis ? ry_r : rx_r;
    lo_sel   = cmd.axis ? crop_y_low_r  : crop_x_low_r;
    hi_sel   = cmd.axis ? crop_y_high_r : crop_x_high_r;
    size_sel = cmd.axis ? screen_h_r    : screen_w_r;
    diff     = $signed({1'b0, M'(raw_sel)}) - $signed({1'b0, M'(lo_sel)});
    diff_mag = diff[M] ? M'(-diff) : M'(diff);
    span     = $signed({1'b0, hi_sel}) - $signed({1'b0, lo_sel});
    span_mag = span[CROP_W] ? CROP_W'(-span) : CROP_W'(span);
    // A negative quotient, a zero span or a zero size all end up as zero.
    force_zero = (span == '0) || (size_sel == '0) || (diff[M] != span[CROP_W]);
    size_m1_w  = TW'(size_sel) - TW'(1);
    mask_w     = TW'({CB{1'b1}});
    top        = (size_m1_w > mask_w) ? CB'(mask_w) : CB'(size_m1_w);
  end

  // Restoring divider: quotient shifts in from the right of the dividend
  logic [NUM_W-1:0]  quo_r;
  logic [CROP_W-1:0] rem_r;
  logic [CROP_W-1:0] span_mag_r;
  logic              force_zero_r;
  logic [CB-1:0]     top_r;
  logic [CROP_W:0]   trial, trial_sub;
  logic              trial_ge;

  always_comb begin
    trial     = {rem_r, quo_r[NUM_W-1]};
    trial_ge  = (trial >= {1'b0, span_mag_r});
    trial_sub = trial - {1'b0, span_mag_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      quo_r        <= NUM_W'(diff_mag) * NUM_W'(size_sel);
      rem_r        <= '0;
      span_mag_r   <= span_mag;
      force_zero_r <= force_zero;
      top_r        <= top;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[NUM_W-2:0], trial_ge};
      rem_r <= trial_ge ? trial_sub[CROP_W-1:0] : trial[CROP_W-1:0];
    end
  end

  // Clamp and store each axis result
  logic [CB-1:0] scaled;
  logic [CB-1:0] new_x_r, new_y_r;

  always_comb begin
    if (force_zero_r) begin
      scaled = '0;
    end else if (quo_r > NUM_W'(top_r)) begin
      scaled = top_r;
    end else begin
      scaled = CB'(quo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (cmd.axis) begin
        new_y_r <= scaled;
      end else begin
        new_x_r <= scaled;
      end
    end
  end

  // Stroke classification on release
  logic signed [GW-1:0] dx, dy, adx, ady, slide_w;
  logic [GEST_W-1:0]    gest_new;

  always_comb begin
    dx      = $signed(GW'(new_x_r)) - $signed(GW'(rep_press_x_r));
    dy      = $signed(GW'(new_y_r)) - $signed(GW'(rep_press_y_r));
    adx     = dx[GW-1] ? -dx : dx;
    ady     = dy[GW-1] ? -dy : dy;
    slide_w = $signed(GW'(slide_dist_r));
    if ((adx < $signed(GW'(tap_radius_r))) && (ady < $signed(GW'(tap_radius_r)))) begin
      gest_new = GEST_TAP;
    end else if (dx > slide_w) begin
      gest_new = GEST_RIGHT;
    end else if (dx < -slide_w) begin
      gest_new = GEST_LEFT;
    end else begin
      gest_new = GEST_NONE;
    end
  end

  // Report update and output register load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_touch_r  <= 1'b0;
      last_x_r      <= '0;
      last_y_r      <= '0;
      rep_touched_r <= 1'b0;
      rep_x_r       <= '0;
      rep_y_r       <= '0;
      rep_press_x_r <= '0;
      rep_press_y_r <= '0;
      rep_lift_x_r  <= '0;
      rep_lift_y_r  <= '0;
      rep_gesture_r <= GEST_NONE;
      updated_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.finish) begin
        updated_r <= changed_r || (rep_gesture_r != GEST_NONE);
        // A gesture lives for one report; only a release sets a new one.
        rep_gesture_r <= (changed_r && rep_touched_r && !t_r) ? gest_new : GEST_NONE;
        if (changed_r) begin
          last_touch_r  <= t_r;
          last_x_r      <= rx_r;
          last_y_r      <= ry_r;
          rep_touched_r <= t_r;
          rep_x_r       <= new_x_r;
          rep_y_r       <= new_y_r;
          if (!rep_touched_r && t_r) begin
            rep_press_x_r <= new_x_r;
            rep_press_y_r <= new_y_r;
          end else if (rep_touched_r && !t_r) begin
            rep_lift_x_r  <= new_x_r;
            rep_lift_y_r  <= new_y_r;
          end
        end
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign updated     = updated_r;
  assign touched_now = rep_touched_r;
  assign pos_x       = rep_x_r;
  assign pos_y       = rep_y_r;
  assign press_x     = rep_press_x_r;
  assign press_y     = rep_press_y_r;
  assign lift_x      = rep_lift_x_r;
  assign lift_y      = rep_lift_y_r;
  assign gesture     = rep_gesture_r;

  // A gesture is only reported with the finger up.
  a_gesture_released: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && gesture != GEST_NONE) |-> (!touched_now && updated))
    else $error("gesture reported while touched or without update");

  // The report after one carrying a gesture is marked as updated.
  a_gesture_one_report: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && rep_gesture_r != GEST_NONE) |=> (updated_r))
    else $error("gesture clear did not raise updated");

endmodule

`default_nettype wire
